// ----- rtl/trsb_pkg.sv -----
// Shared types, constants and helpers of the trail ribbon strip builder.
`timescale 1ns / 1ps
`default_nettype none
package trsb_pkg;

    localparam int OBJ_W  = 8;   // object number, enough for 256 objects
    localparam int SLOT_W = 5;   // history slot, enough for 32 points
    localparam int CNT_W  = 6;   // point count, holds 0..32

    typedef struct packed {
        logic [3:0]         mesh_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [30:0]        radius;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_z;
        logic [4:0]         point_slot;
        logic               side;
        logic               last;
    } t_out_word;

    // one strip job handed from the front to the back
    typedef struct packed {
        logic [OBJ_W-1:0]   obj;
        logic [SLOT_W-1:0]  wr_slot;
        logic [SLOT_W-1:0]  old_slot;
        logic [CNT_W-1:0]   count;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [30:0]        radius;
    } t_job;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic [31:0] res;
        if (v > 34'sd2147483647) begin
            res = 32'h7FFF_FFFF;
        end else if (v < -34'sd2147483648) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/trsb_ifs.sv -----
// Valid/ready channel interfaces for the input and result words.
`timescale 1ns / 1ps
`default_nettype none
interface trsb_in_if;
    import trsb_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word word;
    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface

interface trsb_out_if;
    import trsb_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word word;
    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface
`default_nettype wire

// ----- rtl/trsb_front.sv -----
// Front end: accept words, update per-object fill state, issue strip jobs.
`timescale 1ns / 1ps
`default_nettype none
module trsb_front #(
    parameter int TRAIL_DEPTH = 32,
    parameter int MAX_OBJECTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    trsb_in_if.sink             i_in,
    input  trsb_pkg::t_q_stat   i_stat,
    output logic                o_push,
    output trsb_pkg::t_job      o_job
);
    import trsb_pkg::*;

    localparam int OW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int TD = TRAIL_DEPTH;

    logic [CNT_W-1:0]  r_fill [MAX_OBJECTS];
    logic [SLOT_W-1:0] r_old  [MAX_OBJECTS];

    logic [OBJ_W+3:0]  obj_ext;
    logic [OW-1:0]     obj_idx;
    logic              obj_ok;
    logic              accept;
    logic [CNT_W-1:0]  cur_n;
    logic [SLOT_W-1:0] cur_old;
    logic [CNT_W:0]    wsum;
    logic [CNT_W:0]    oinc;
    logic [SLOT_W-1:0] n_wr;
    logic [SLOT_W-1:0] n_old;
    logic [CNT_W-1:0]  n_fill;

    assign obj_ext = (OBJ_W + 4)'(i_in.word.mesh_index);
    assign obj_idx = obj_ext[OW-1:0];
    assign obj_ok  = 32'(obj_ext) < 32'(MAX_OBJECTS);
    assign i_in.ready = !i_stat.full;
    assign accept  = i_in.valid && !i_stat.full;

    always_comb begin
        cur_n   = r_fill[obj_idx];
        cur_old = r_old[obj_idx];
        wsum    = (CNT_W + 1)'(cur_old) + (CNT_W + 1)'(cur_n);
        oinc    = (CNT_W + 1)'(cur_old) + 1'b1;
        if (32'(cur_n) < TD) begin
            // room left: append behind the newest point
            if (32'(wsum) >= TD) begin
                wsum = wsum - (CNT_W + 1)'(TD);
            end
            n_wr   = SLOT_W'(wsum);
            n_old  = cur_old;
            n_fill = cur_n + 1'b1;
        end else begin
            // full: overwrite the oldest point and advance past it
            if (32'(oinc) >= TD) begin
                oinc = '0;
            end
            n_wr   = cur_old;
            n_old  = SLOT_W'(oinc);
            n_fill = cur_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_OBJECTS; i++) begin
                r_fill[i] <= '0;
                r_old[i]  <= '0;
            end
        end else if (accept && obj_ok) begin
            r_fill[obj_idx] <= n_fill;
            r_old[obj_idx]  <= n_old;
        end
    end

    assign o_push        = accept && obj_ok;
    assign o_job.obj     = OBJ_W'(obj_ext);
    assign o_job.wr_slot = n_wr;
    assign o_job.old_slot = n_old;
    assign o_job.count   = n_fill;
    assign o_job.px      = i_in.word.pos_x;
    assign o_job.py      = i_in.word.pos_y;
    assign o_job.pz      = i_in.word.pos_z;
    assign o_job.radius  = i_in.word.radius;

endmodule
`default_nettype wire

// ----- rtl/trsb_fifo.sv -----
// Two-entry job queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module trsb_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  trsb_pkg::t_job    i_job,
    input  logic              i_pop,
    output trsb_pkg::t_job    o_job,
    output trsb_pkg::t_q_stat o_stat
);
    import trsb_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_job = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule
`default_nettype wire

// ----- rtl/trsb_back.sv -----
// Back end: history memory, direction, normalize, sqrt, divide, emit vertices.
`timescale 1ns / 1ps
`default_nettype none
module trsb_back #(
    parameter int TRAIL_DEPTH = 32,
    parameter int MAX_OBJECTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  trsb_pkg::t_job    i_job,
    input  trsb_pkg::t_q_stat i_stat,
    output logic              o_pop,
    trsb_out_if.source        o_out
);
    import trsb_pkg::*;

    localparam int TD    = TRAIL_DEPTH;
    localparam int DEPTH = MAX_OBJECTS * TRAIL_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_WR    = 12'b0000_0000_0010,
        S_RDP   = 12'b0000_0000_0100,
        S_RDN   = 12'b0000_0000_1000,
        S_CAPN  = 12'b0000_0001_0000,
        S_NORM  = 12'b0000_0010_0000,
        S_SQ    = 12'b0000_0100_0000,
        S_SQRT  = 12'b0000_1000_0000,
        S_MUL   = 12'b0001_0000_0000,
        S_DIV   = 12'b0010_0000_0000,
        S_EMIT0 = 12'b0100_0000_0000,
        S_EMIT1 = 12'b1000_0000_0000
    } t_state;

    logic [31:0] mem_x [DEPTH];
    logic [31:0] mem_y [DEPTH];
    logic [31:0] mem_z [DEPTH];

    t_state             r_state;
    t_job               r_job;
    logic [CNT_W-1:0]   r_j;
    logic [SLOT_W-1:0]  r_slot;
    logic signed [31:0] r_rd_x, r_rd_y, r_rd_z;
    logic signed [31:0] r_px, r_pz;
    logic [32:0]        r_ax, r_ay, r_az;
    logic               r_neg_ox, r_neg_oz;
    logic [1:0]         r_cnt;
    logic [61:0]        r_acc;
    logic [62:0]        r_bit, r_res;
    logic [30:0]        r_len;
    logic               r_pass;
    logic [31:0]        r_lo, r_rem;
    logic [4:0]         r_step;
    logic signed [32:0] r_ox, r_oz;
    logic               r_ov;
    t_out_word          r_ow;

    logic [SLOT_W-1:0]  nxt_slot;
    logic [CNT_W:0]     slot_inc;
    logic [SLOT_W-1:0]  rd_slot;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic               is_last;
    logic               can_load;
    logic               load_ow;
    logic signed [32:0] dx, dy, dz;
    logic [32:0]        m;
    logic [29:0]        sq_a;
    logic [63:0]        trial;
    logic               sq_ge;
    logic [62:0]        res_nx;
    logic [29:0]        mul_a;
    logic [61:0]        prod;
    logic [31:0]        dsh;
    logic               dge;
    logic [31:0]        rem_nx;
    logic [31:0]        lo_nx;
    logic signed [32:0] q_s;
    logic signed [33:0] vx, vz;

    always_comb begin
        slot_inc = (CNT_W + 1)'(r_slot) + 1'b1;
        if (32'(slot_inc) >= TD) begin
            slot_inc = '0;
        end
        nxt_slot = SLOT_W'(slot_inc);
        rd_slot  = (r_state == S_RDN) ? nxt_slot : r_slot;
        rd_addr  = AW'(32'(r_job.obj) * TD + 32'(rd_slot));
        wr_addr  = AW'(32'(r_job.obj) * TD + 32'(r_job.wr_slot));
    end

    assign is_last  = (r_j == r_job.count - 1'b1);
    assign can_load = !r_ov || o_out.ready;
    assign load_ow  = ((r_state == S_EMIT0) || (r_state == S_EMIT1)) && can_load;
    assign o_pop    = (r_state == S_IDLE) && !i_stat.empty;

    // history store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (r_state == S_WR) begin
            mem_x[wr_addr] <= r_job.px;
            mem_y[wr_addr] <= r_job.py;
            mem_z[wr_addr] <= r_job.pz;
        end
        r_rd_x <= mem_x[rd_addr];
        r_rd_y <= mem_y[rd_addr];
        r_rd_z <= mem_z[rd_addr];
    end

    // direction and its magnitudes
    always_comb begin
        dx = 33'(r_rd_x) - 33'(r_px);
        dy = 33'(r_rd_y) - 33'(r_job.py);
        dz = 33'(r_rd_z) - 33'(r_pz);
    end

    always_comb begin
        m = r_ax;
        if (r_ay > m) begin
            m = r_ay;
        end
        if (r_az > m) begin
            m = r_az;
        end
    end

    always_comb begin
        unique case (r_cnt)
            2'd0:    sq_a = r_ax[29:0];
            2'd1:    sq_a = r_ay[29:0];
            default: sq_a = r_az[29:0];
        endcase
        trial  = 64'(r_res) + 64'(r_bit);
        sq_ge  = 64'(r_acc) >= trial;
        res_nx = sq_ge ? (r_res >> 1) + r_bit : r_res >> 1;
        mul_a  = r_pass ? r_ax[29:0] : r_az[29:0];
        prod   = 62'(mul_a) * 62'(r_job.radius) + 62'(r_len >> 1);
        dsh    = {r_rem[30:0], r_lo[31]};
        dge    = dsh >= {1'b0, r_len};
        rem_nx = dge ? dsh - {1'b0, r_len} : dsh;
        lo_nx  = {r_lo[30:0], dge};
        if (r_pass ? r_neg_oz : r_neg_ox) begin
            q_s = -$signed({1'b0, lo_nx});
        end else begin
            q_s = $signed({1'b0, lo_nx});
        end
        vx = (r_state == S_EMIT1) ? 34'(r_px) - 34'(r_ox) : 34'(r_px) + 34'(r_ox);
        vz = (r_state == S_EMIT1) ? 34'(r_pz) - 34'(r_oz) : 34'(r_pz) + 34'(r_oz);
    end

    // output register: load a vertex, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load_ow) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_stat.empty) begin
                        r_job   <= i_job;
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    r_slot  <= r_job.old_slot;
                    r_j     <= '0;
                    r_state <= S_RDP;
                end
                S_RDP: begin
                    r_state <= S_RDN;
                end
                S_RDN: begin
                    r_px <= r_rd_x;
                    r_pz <= r_rd_z;
                    r_job.py <= r_rd_y;
                    if (r_job.count == CNT_W'(1)) begin
                        r_ox    <= '0;
                        r_oz    <= -$signed({2'b0, r_job.radius});
                        r_state <= S_EMIT0;
                    end else if (is_last) begin
                        // newest point reuses the previous segment's offset
                        r_state <= S_EMIT0;
                    end else begin
                        r_state <= S_CAPN;
                    end
                end
                S_CAPN: begin
                    r_ax     <= dx[32] ? 33'(-dx) : 33'(dx);
                    r_ay     <= dy[32] ? 33'(-dy) : 33'(dy);
                    r_az     <= dz[32] ? 33'(-dz) : 33'(dz);
                    r_neg_ox <= dz[32];
                    r_neg_oz <= !dx[32] && (dx != '0);
                    if (dx == '0 && dy == '0 && dz == '0) begin
                        r_ox    <= '0;
                        r_oz    <= '0;
                        r_state <= S_EMIT0;
                    end else begin
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (m >= 33'h0_4000_0000) begin
                        r_ax <= r_ax >> 1;
                        r_ay <= r_ay >> 1;
                        r_az <= r_az >> 1;
                    end else if (m < 33'h0_0020_0000) begin
                        r_ax <= r_ax << 8;
                        r_ay <= r_ay << 8;
                        r_az <= r_az << 8;
                    end else if (m < 33'h0_2000_0000) begin
                        r_ax <= r_ax << 1;
                        r_ay <= r_ay << 1;
                        r_az <= r_az << 1;
                    end else begin
                        r_cnt   <= '0;
                        r_acc   <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_acc <= r_acc + 62'(60'(sq_a) * 60'(sq_a));
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 2'd2) begin
                        r_res   <= '0;
                        r_bit   <= 63'h4000_0000_0000_0000;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sq_ge) begin
                        r_acc <= r_acc - trial[61:0];
                    end
                    r_res <= res_nx;
                    r_bit <= r_bit >> 2;
                    if (r_bit == 63'd1) begin
                        r_len   <= res_nx[30:0];
                        r_pass  <= 1'b0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_rem   <= {2'b0, prod[61:32]};
                    r_lo    <= prod[31:0];
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= rem_nx;
                    r_lo   <= lo_nx;
                    r_step <= r_step + 1'b1;
                    if (r_step == 5'd31) begin
                        if (r_pass) begin
                            r_oz    <= q_s;
                            r_state <= S_EMIT0;
                        end else begin
                            r_ox    <= q_s;
                            r_pass  <= 1'b1;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_EMIT0: begin
                    if (can_load) begin
                        r_ow.vert_x     <= sat32(vx);
                        r_ow.vert_z     <= sat32(vz);
                        r_ow.point_slot <= 5'(r_j);
                        r_ow.side       <= 1'b0;
                        r_ow.last       <= 1'b0;
                        r_state         <= S_EMIT1;
                    end
                end
                S_EMIT1: begin
                    if (can_load) begin
                        r_ow.vert_x     <= sat32(vx);
                        r_ow.vert_z     <= sat32(vz);
                        r_ow.point_slot <= 5'(r_j);
                        r_ow.side       <= 1'b1;
                        r_ow.last       <= is_last;
                        if (is_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_slot  <= nxt_slot;
                            r_state <= S_RDP;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.word  = r_ow;

endmodule
`default_nettype wire

// ----- rtl/trail_ribbon_strip_builder_unit.sv -----
// Top level of the trail ribbon strip builder.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   i_in carries one position word per update: object number, Q16.16
//   position and trail radius. o_out returns the object's triangle-strip
//   vertices, two per stored point, oldest point first, with last set on the
//   final vertex. Words for an object number at or above MAX_OBJECTS are
//   taken and dropped without any result.
//   The front accepts a word and queues a strip job; a two-entry
//   queue lets it take up to two more words while the back is busy.
//   The back runs each stored point except the newest (which reuses the
//   previous segment's offset) through the bit-serial square root and the
//   shared restoring divider, run twice. It finishes a whole strip before
//   it takes the next job from the queue.
//   Reset empties every object's history at once; the history store itself
//   needs no clearing pass. When the receiver stalls, the vertex is held in
//   the output register and the back waits; the front keeps taking words
//   until the queue fills.
module trail_ribbon_strip_builder_unit #(
    parameter int TRAIL_DEPTH = 32,
    parameter int MAX_OBJECTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    trsb_in_if.sink     i_in,
    trsb_out_if.source  o_out
);
    import trsb_pkg::*;

    logic    push;
    logic    pop;
    t_job    push_job;
    t_job    head_job;
    t_q_stat q_stat;

    // accept and classify
    trsb_front #(
        .TRAIL_DEPTH (TRAIL_DEPTH),
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_stat  (q_stat),
        .o_push  (push),
        .o_job   (push_job)
    );

    // decouple the two sides
    trsb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    // store the point and build the strip
    trsb_back #(
        .TRAIL_DEPTH (TRAIL_DEPTH),
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (head_job),
        .i_stat  (q_stat),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire
